>>> src/gfgc_pkg.sv
// gfgc_pkg: shared types, codes and sizes for the greedy first-fit graph coloring block
// no dependencies
package gfgc_pkg;

    localparam int MAX_VERTICES = 1024;

    typedef enum logic [1:0] {
        ACT_CLR_COLOR = 2'd0,
        ACT_ADD_EDGE  = 2'd1,
        ACT_COLOR     = 2'd2,
        ACT_CLR_EDGES = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_COLORED = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WR,
        S_CLR_ADJ,
        S_CLR_COL,
        S_CHK,
        S_SCAN,
        S_MARKCLR,
        S_SEARCH,
        S_DONE,
        S_OUT
    } t_state;

endpackage

>>> src/gfgc_if.sv
// gfgc_in_if / gfgc_out_if: valid/ready channels carrying the payloads
// depends on nothing
interface gfgc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [9:0] vertex_a;
    logic [9:0] vertex_b;
    modport source (output valid, action, vertex_a, vertex_b, input ready);
    modport sink   (input valid, action, vertex_a, vertex_b, output ready);
endinterface

interface gfgc_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  assigned_color;
    logic [10:0] color_count;
    logic [1:0]  status;
    modport source (output valid, assigned_color, color_count, status, input ready);
    modport sink   (input valid, assigned_color, color_count, status, output ready);
endinterface

>>> src/gfgc_mem.sv
// gfgc_mem: single-port-write, registered-read memory
// no dependencies
module gfgc_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/greedy_first_fit_graph_coloring.sv
// greedy_first_fit_graph_coloring: top level, sequencer around adjacency and
// color memories and a small mark file; depends on gfgc_pkg, gfgc_if, gfgc_mem
//
//  channel  dir  handshake      payload
//  in       in   valid/ready    action, vertex_a, vertex_b
//  out      out  valid/ready    assigned_color, color_count, status
//  cfg      in   i_cfg_we       i_cfg_data (vertex_count)
//
// after reset a clearing pass wipes the adjacency memory and the color memory;
// in_ch.ready stays low meanwhile
// color request: a scan of the n active vertices, one neighbor per cycle, then a
// search of the mark words up to w, the mark word of the color that is assigned;
// one item at a time, a held result stalls the input
module greedy_first_fit_graph_coloring (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data,
    gfgc_in_if.sink     in_ch,
    gfgc_out_if.source  out_ch
);
    localparam int MAX_VERTICES = gfgc_pkg::MAX_VERTICES;
    localparam int RW = (MAX_VERTICES + 63) / 64;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int WW = (RW > 1) ? $clog2(RW) : 1;
    localparam int AD = MAX_VERTICES * RW;
    localparam int AW = $clog2(AD);
    localparam int CW = VW + 1;

    logic [10:0]         r_vcount;
    gfgc_pkg::t_state    r_state, n_state;
    logic [1:0]          r_act;
    logic [9:0]          r_va, r_vb;
    logic [12:0]         r_n;
    logic [AW:0]         r_cnt, n_cnt;
    logic                n_rdv;
    logic [CW-1:0]       r_hi, n_hi;
    logic [VW-1:0]       r_col, n_col;
    logic [1:0]          r_stat, n_stat;
    logic                r_ovalid, n_ovalid;

    // adjacency
    logic              adj_we;
    logic [AW-1:0]     adj_wa, adj_ra;
    logic [63:0]       adj_wd, adj_rd;
    // colors
    logic              col_we;
    logic [VW-1:0]     col_wa, col_ra;
    logic [CW-1:0]     col_wd, col_rd;

    gfgc_mem #(.WIDTH(64), .DEPTH(AD)) u_adj (
        .i_clk, .i_we(adj_we), .i_waddr(adj_wa), .i_wdata(adj_wd),
        .i_raddr(adj_ra), .o_rdata(adj_rd));
    gfgc_mem #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_col (
        .i_clk, .i_we(col_we), .i_waddr(col_wa), .i_wdata(col_wd),
        .i_raddr(col_ra), .o_rdata(col_rd));

    // pipeline regs for scan: neighbor index and its valid flag
    logic [VW-1:0] r_pj;
    logic          r_pv;

    // neighbor color marks, one word per 64 colors
    logic [63:0]   r_marks [RW];

    logic [12:0] n_in;
    assign n_in = (r_vcount > 11'(MAX_VERTICES)) ? 13'(MAX_VERTICES) : 13'(r_vcount);

    logic [AW-1:0] row_base_a, row_base_b;
    assign row_base_a = AW'(32'(r_va) * RW);
    assign row_base_b = AW'(32'(r_vb) * RW);

    logic [63:0] mk_word;
    assign mk_word = r_marks[r_cnt[WW-1:0]];

    logic [5:0] free_pos;
    logic       free_any;
    always_comb begin
        free_pos = '0;
        free_any = 1'b0;
        for (int k = 63; k >= 0; k--) begin
            if (!mk_word[k]) begin
                free_pos = 6'(k);
                free_any = 1'b1;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rdv    = 1'b0;
        n_hi     = r_hi;
        n_col    = r_col;
        n_stat   = r_stat;
        n_ovalid = r_ovalid;
        adj_we = 1'b0; adj_wa = r_cnt[AW-1:0]; adj_wd = '0; adj_ra = row_base_a;
        col_we = 1'b0; col_wa = r_cnt[VW-1:0]; col_wd = '0; col_ra = r_va[VW-1:0];
        in_ch.ready = 1'b0;
        if (r_ovalid && out_ch.ready) n_ovalid = 1'b0;
        case (r_state)
            gfgc_pkg::S_INIT: begin
                adj_we = 1'b1;
                col_we = (r_cnt < (AW+1)'(MAX_VERTICES));
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(AD - 1)) begin
                    n_state = gfgc_pkg::S_IDLE;
                    n_cnt   = '0;
                end
            end
            gfgc_pkg::S_IDLE: begin
                in_ch.ready = !r_ovalid;
                n_cnt = '0;
                if (in_ch.valid && !r_ovalid) begin
                    n_col  = '0;
                    n_stat = gfgc_pkg::ST_OK;
                    case (gfgc_pkg::t_action'(in_ch.action))
                        gfgc_pkg::ACT_CLR_COLOR: n_state = gfgc_pkg::S_CLR_COL;
                        gfgc_pkg::ACT_CLR_EDGES: n_state = gfgc_pkg::S_CLR_ADJ;
                        gfgc_pkg::ACT_ADD_EDGE:  n_state = gfgc_pkg::S_EDGE_RD;
                        default:                 n_state = gfgc_pkg::S_CHK;
                    endcase
                end
            end
            gfgc_pkg::S_CLR_COL: begin
                col_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                n_hi   = '0;
                if (r_cnt == (AW+1)'(MAX_VERTICES - 1)) n_state = gfgc_pkg::S_OUT;
            end
            gfgc_pkg::S_CLR_ADJ: begin
                adj_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(AD - 1)) n_state = gfgc_pkg::S_OUT;
            end
            gfgc_pkg::S_EDGE_RD: begin
                if (13'(r_va) >= r_n || 13'(r_vb) >= r_n) begin
                    n_stat  = gfgc_pkg::ST_RANGE;
                    n_state = gfgc_pkg::S_OUT;
                end else begin
                    adj_ra  = row_base_a + AW'(r_vb[9:6]);
                    n_state = gfgc_pkg::S_EDGE_WR;
                end
            end
            gfgc_pkg::S_EDGE_WR: begin
                // cnt 0: write a row word, read b row word; 1: write b row word
                n_cnt  = r_cnt + 1'b1;
                adj_we = 1'b1;
                if (r_cnt == '0) begin
                    adj_wa = row_base_a + AW'(r_vb[9:6]);
                    adj_wd = adj_rd | (64'd1 << r_vb[5:0]);
                    adj_ra = row_base_b + AW'(r_va[9:6]);
                end else begin
                    // a self loop hits the same word and the same bit, so old data is fine
                    adj_wa  = row_base_b + AW'(r_va[9:6]);
                    adj_wd  = adj_rd | (64'd1 << r_va[5:0]);
                    n_state = gfgc_pkg::S_OUT;
                end
            end
            gfgc_pkg::S_CHK: begin
                // cnt 0 issue color read, 1 look at it
                col_ra = r_va[VW-1:0];
                n_cnt  = r_cnt + 1'b1;
                if (13'(r_va) >= r_n) begin
                    n_stat  = gfgc_pkg::ST_RANGE;
                    n_state = gfgc_pkg::S_OUT;
                end else if (r_cnt != '0) begin
                    n_cnt = '0;
                    if (col_rd != '0) begin
                        n_stat  = gfgc_pkg::ST_COLORED;
                        n_state = gfgc_pkg::S_OUT;
                    end else begin
                        n_state = gfgc_pkg::S_MARKCLR;
                    end
                end
            end
            gfgc_pkg::S_MARKCLR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(RW - 1)) begin
                    n_cnt   = '0;
                    n_state = gfgc_pkg::S_SCAN;
                end
            end
            gfgc_pkg::S_SCAN: begin
                // issue reads for neighbor r_cnt; its mark is set in the next cycle from the read data
                col_ra = r_cnt[VW-1:0];
                adj_ra = row_base_a + AW'(r_cnt[VW-1:6]);
                n_cnt  = r_cnt + 1'b1;
                n_rdv  = (r_cnt < (AW+1)'(r_n));
                if (r_cnt >= (AW+1)'(r_n)) begin
                    n_cnt = r_cnt;
                    if (!r_pv) begin
                        n_cnt   = '0;
                        n_state = gfgc_pkg::S_SEARCH;
                    end
                end
            end
            gfgc_pkg::S_SEARCH: begin
                // one mark word per cycle, lowest clear bit wins
                n_cnt = r_cnt + 1'b1;
                if (free_any) begin
                    n_col   = {r_cnt[WW-1:0], free_pos};
                    n_state = gfgc_pkg::S_DONE;
                end else if (r_cnt == (AW+1)'(RW - 1)) begin
                    n_col   = VW'(MAX_VERTICES - 1);
                    n_state = gfgc_pkg::S_DONE;
                end
            end
            gfgc_pkg::S_DONE: begin
                col_we = 1'b1;
                col_wa = r_va[VW-1:0];
                col_wd = CW'(r_col) + 1'b1;
                if (r_hi < col_wd) n_hi = col_wd;
                n_state = gfgc_pkg::S_OUT;
            end
            gfgc_pkg::S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = gfgc_pkg::S_IDLE;
            end
            default: n_state = gfgc_pkg::S_IDLE;
        endcase
    end

    logic          pend;
    logic [CW-1:0] pc;
    assign pc   = col_rd - 1'b1;
    assign pend = r_state == gfgc_pkg::S_SCAN && r_pv && col_rd != '0
                  && col_rd <= CW'(MAX_VERTICES) && adj_rd[r_pj[5:0]];

    always_ff @(posedge i_clk) begin
        r_pj <= r_cnt[VW-1:0];
        if (r_state == gfgc_pkg::S_MARKCLR) r_marks[r_cnt[WW-1:0]] <= '0;
        if (pend) r_marks[pc[VW-1:6]][pc[5:0]] <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gfgc_pkg::S_INIT;
            r_cnt    <= '0;
            r_vcount <= 11'd1024;
            r_hi     <= '0;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_hi     <= n_hi;
            r_ovalid <= n_ovalid;
            r_pv     <= n_rdv;
            if (i_cfg_we) r_vcount <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col  <= n_col;
        r_stat <= n_stat;
        if (in_ch.valid && in_ch.ready) begin
            r_act <= in_ch.action;
            r_va  <= in_ch.vertex_a;
            r_vb  <= in_ch.vertex_b;
            r_n   <= n_in;
        end
    end

    assign out_ch.valid          = r_ovalid;
    assign out_ch.assigned_color = (r_act == gfgc_pkg::ACT_COLOR && r_stat == gfgc_pkg::ST_OK)
                                   ? r_col : 10'd0;
    assign out_ch.color_count    = r_hi;
    assign out_ch.status         = r_stat;
endmodule

>>> sim/gfgc_color_checker.sv
// gfgc_color_checker: watches the item and result channels, predicts each result
// of the graph coloring block and compares it field by field; depends on gfgc_pkg
module gfgc_color_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_action,
    input  logic [9:0]  i_vertex_a,
    input  logic [9:0]  i_vertex_b,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [9:0]  i_assigned_color,
    input  logic [10:0] i_color_count,
    input  logic [1:0]  i_status,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_VERTICES = gfgc_pkg::MAX_VERTICES;

    typedef struct packed {
        logic [9:0]        color;
        logic [10:0]       used;
        gfgc_pkg::t_status status;
    } t_coloring;

    logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
    logic [10:0] color_p1 [MAX_VERTICES];
    logic [10:0] top_color_p1;
    logic [10:0] vtx_count;
    t_coloring   expected_colorings [$];

    function automatic t_coloring color_step(gfgc_pkg::t_action act, int a, int b);
        t_coloring r;
        int n;
        logic [MAX_VERTICES-1:0] taken;
        int c;
        r = '0;
        r.status = gfgc_pkg::ST_OK;
        n = (vtx_count < MAX_VERTICES) ? vtx_count : MAX_VERTICES;
        case (act)
            gfgc_pkg::ACT_CLR_COLOR: begin
                foreach (color_p1[i]) color_p1[i] = '0;
                top_color_p1 = '0;
            end
            gfgc_pkg::ACT_CLR_EDGES: begin
                foreach (adj_rows[i]) adj_rows[i] = '0;
            end
            gfgc_pkg::ACT_ADD_EDGE: begin
                if (a >= n || b >= n) r.status = gfgc_pkg::ST_RANGE;
                else begin
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                end
            end
            default: begin
                if (a >= n) r.status = gfgc_pkg::ST_RANGE;
                else if (color_p1[a] != 0) r.status = gfgc_pkg::ST_COLORED;
                else begin
                    taken = '0;
                    for (int j = 0; j < n; j++)
                        if (color_p1[j] != 0 && color_p1[j] <= MAX_VERTICES && adj_rows[a][j])
                            taken[color_p1[j]-1] = 1'b1;
                    c = MAX_VERTICES - 1;
                    for (int j = 0; j < MAX_VERTICES; j++)
                        if (!taken[j]) begin
                            c = j;
                            break;
                        end
                    color_p1[a] = 11'(c + 1);
                    if (top_color_p1 < c + 1) top_color_p1 = 11'(c + 1);
                    r.color = 10'(c);
                end
            end
        endcase
        r.used = top_color_p1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_coloring want;
        if (!i_rst_n) begin
            foreach (adj_rows[i]) adj_rows[i] = '0;
            foreach (color_p1[i]) color_p1[i] = '0;
            top_color_p1 = '0;
            vtx_count = 11'd1024;
            expected_colorings.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) vtx_count = i_cfg_data;
            if (i_in_valid && i_in_ready)
                expected_colorings.push_back(color_step(gfgc_pkg::t_action'(i_action),
                                                        i_vertex_a, i_vertex_b));
            if (i_out_valid && i_out_ready) begin
                if (expected_colorings.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_errors++;
                end else begin
                    want = expected_colorings.pop_front();
                    if (want.color !== i_assigned_color) begin
                        $error("assigned_color expected %0d got %0d", want.color,
                               i_assigned_color);
                        o_errors++;
                    end
                    if (want.used !== i_color_count) begin
                        $error("color_count expected %0d got %0d", want.used,
                               i_color_count);
                        o_errors++;
                    end
                    if (want.status !== i_status) begin
                        $error("status expected %0d got %0d", want.status, i_status);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_colorings.size();
    end
endmodule

>>> sim/greedy_first_fit_graph_coloring_test.sv
// greedy_first_fit_graph_coloring_test: stimulus and verdict for the coloring block
// depends on gfgc_pkg, gfgc_if, the block and gfgc_color_checker
module greedy_first_fit_graph_coloring_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_data = '0;
    int          errors, pending;
    longint      cycles = 0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;
    int          n_now = 1024;

    gfgc_in_if  in_ch ();
    gfgc_out_if out_ch ();

    greedy_first_fit_graph_coloring dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    gfgc_color_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_action(in_ch.action),
        .i_vertex_a(in_ch.vertex_a), .i_vertex_b(in_ch.vertex_b),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_assigned_color(out_ch.assigned_color), .i_color_count(out_ch.color_count),
        .i_status(out_ch.status), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = '0;
        in_ch.vertex_a = '0;
        in_ch.vertex_b = '0;
        out_ch.ready = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall bursts, a long hold-off when asked, none at the end
    initial begin
        int k;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                k = $urandom_range(1, 14);
                repeat (k) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // valid stays high between back-to-back items; it drops for an idle burst, a vertex count change and at the end
    task automatic send_item(gfgc_pkg::t_action act, int a, int b);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.vertex_a <= a[9:0];
        in_ch.vertex_b <= b[9:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(int v);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[10:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_now = v;
    endtask

    // mostly in-range indices, some beyond the active count
    function automatic int pick_vertex();
        int lim;
        lim = (n_now > 1024) ? 1024 : n_now;
        if (lim == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
        return $urandom_range(0, lim - 1);
    endfunction

    task automatic random_phase(int items);
        int r, v;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2) send_item(gfgc_pkg::ACT_CLR_COLOR, $urandom, $urandom);
            else if (r < 3) send_item(gfgc_pkg::ACT_CLR_EDGES, $urandom, $urandom);
            else if (r < 50) begin
                v = pick_vertex();
                send_item(gfgc_pkg::ACT_ADD_EDGE, v, pick_vertex());
            end else send_item(gfgc_pkg::ACT_COLOR, pick_vertex(), $urandom);
        end
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes at reset count, star graph, errors
        send_item(gfgc_pkg::ACT_ADD_EDGE, 0, 1023);
        send_item(gfgc_pkg::ACT_ADD_EDGE, 1023, 1023);
        send_item(gfgc_pkg::ACT_ADD_EDGE, 5, 1023);
        send_item(gfgc_pkg::ACT_COLOR, 1023, 0);
        send_item(gfgc_pkg::ACT_COLOR, 0, 0);
        send_item(gfgc_pkg::ACT_COLOR, 5, 0);
        send_item(gfgc_pkg::ACT_ADD_EDGE, 0, 5);
        send_item(gfgc_pkg::ACT_ADD_EDGE, 2, 0);
        send_item(gfgc_pkg::ACT_ADD_EDGE, 2, 5);
        send_item(gfgc_pkg::ACT_COLOR, 2, 0);
        send_item(gfgc_pkg::ACT_COLOR, 2, 0);
        send_item(gfgc_pkg::ACT_CLR_EDGES, 0, 0);
        send_item(gfgc_pkg::ACT_COLOR, 3, 682);
        send_item(gfgc_pkg::ACT_CLR_COLOR, 1023, 1023);
        send_item(gfgc_pkg::ACT_COLOR, 1023, 1023);
        set_vertex_count(0);
        send_item(gfgc_pkg::ACT_ADD_EDGE, 0, 0);
        send_item(gfgc_pkg::ACT_COLOR, 0, 0);
        set_vertex_count(2047);
        send_item(gfgc_pkg::ACT_ADD_EDGE, 1023, 0);
        send_item(gfgc_pkg::ACT_COLOR, 0, 0);
        set_vertex_count(1);
        send_item(gfgc_pkg::ACT_COLOR, 0, 0);
        send_item(gfgc_pkg::ACT_ADD_EDGE, 0, 1);
        send_item(gfgc_pkg::ACT_CLR_COLOR, 0, 0);

        // dense small graphs so that colors climb
        set_vertex_count(16);
        fork
            begin
                hold_off = 1'b1;
                random_phase(40);
            end
        join
        set_vertex_count(1024);
        random_phase(60);
        set_vertex_count(40);
        random_phase(150);
        set_vertex_count(8);   // shrink below colored vertices
        random_phase(80);
        set_vertex_count(1);
        random_phase(20);
        set_vertex_count(64);
        random_phase(120);
        calm = 1'b1;
        set_vertex_count(24);
        random_phase(50);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> greedy_first_fit_graph_coloring.f
src/gfgc_pkg.sv
src/gfgc_if.sv
src/gfgc_mem.sv
src/greedy_first_fit_graph_coloring.sv
sim/gfgc_color_checker.sv
sim/greedy_first_fit_graph_coloring_test.sv
